### rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 sequence decoder.
package u8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 21;
  localparam int unsigned CountW  = 3;
  localparam int unsigned StatusW = 2;

  localparam logic [CodeW-1:0] MaxScalar = 21'h10FFFF;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StBadLead = 2'd1,
    StZero    = 2'd2,
    StBadCont = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] fourth_byte;
    logic [ByteW-1:0] third_byte;
    logic [ByteW-1:0] second_byte;
    logic [ByteW-1:0] lead_byte;
  } seq_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] byte_count;
    logic [CodeW-1:0]  code_point;
  } result_t;

endpackage

### rtl/u8d_decode.sv
// Combinational decode of one registered UTF-8 sequence into a result.
module u8d_decode (
  input  u8d_pkg::seq_t   seq_i,
  output u8d_pkg::result_t res_o
);

  logic [u8d_pkg::ByteW-1:0]  b [4];
  logic [u8d_pkg::CountW-1:0] len;
  logic                       lead_ok;
  logic [u8d_pkg::CodeW-1:0]  val;
  u8d_pkg::status_e           st;

  assign b[0] = seq_i.lead_byte;
  assign b[1] = seq_i.second_byte;
  assign b[2] = seq_i.third_byte;
  assign b[3] = seq_i.fourth_byte;

  always_comb begin
    lead_ok = 1'b1;
    val     = '0;
    if (!b[0][7]) begin
      len = 3'd1;
      val = {14'd0, b[0][6:0]};
    end else if (b[0][7:5] == 3'b110) begin
      len = 3'd2;
      val = {10'd0, b[0][4:0], b[1][5:0]};
    end else if (b[0][7:4] == 4'b1110) begin
      len = 3'd3;
      val = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
    end else if (b[0][7:3] == 5'b11110) begin
      len = 3'd4;
      val = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
    end else begin
      len     = 3'd0;
      lead_ok = 1'b0;
    end
  end

  // Bytes are checked in order; the first failing byte within the length decides.
  always_comb begin
    st = u8d_pkg::StOk;
    for (int i = 0; i < 4; i++) begin
      if (st == u8d_pkg::StOk && 3'(i) < len) begin
        if (b[i] == '0) begin
          st = u8d_pkg::StZero;
        end else if (i > 0 && b[i][7:6] != 2'b10) begin
          st = u8d_pkg::StBadCont;
        end
      end
    end
  end

  always_comb begin
    if (!lead_ok) begin
      res_o.status     = u8d_pkg::StBadLead;
      res_o.byte_count = '0;
      res_o.code_point = '0;
    end else if (st != u8d_pkg::StOk) begin
      res_o.status     = st;
      res_o.byte_count = len;
      res_o.code_point = '0;
    end else if (val > u8d_pkg::MaxScalar) begin
      // Out of the Unicode range: hand back the raw lead byte on its own.
      res_o.status     = u8d_pkg::StOk;
      res_o.byte_count = 3'd1;
      res_o.code_point = {13'd0, b[0]};
    end else begin
      res_o.status     = u8d_pkg::StOk;
      res_o.byte_count = len;
      res_o.code_point = val;
    end
  end

endmodule

### rtl/utf8_sequence_decoder.sv
// Top level of the UTF-8 sequence decoder: input stage, decode and result register.
//
// The slave channel takes one sequence per item: four bytes in tdata, lead byte
// lowest. Bytes beyond the length given by the lead byte are ignored.
// The master channel gives one result per item: code point and byte count in
// tdata, status in tuser (ok, bad lead, zero byte, bad continuation).
// An item is registered on acceptance, decoded by combinational logic and caught
// in the result register once that register is free or its item is taken.
// Throughput is one item per cycle while the receiver does not stall; a single
// decode path lies between the two registers.
// When the receiver stalls, the result register holds its item and the input
// stage still takes one more item, after which s_axis_tready_o falls until the
// result is taken. Reset empties both stages; no state survives between items.
module utf8_sequence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] lead_byte, [15:8] second_byte, [23:16] third_byte, [31:24] fourth_byte
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [20:0] code_point, [23:21] byte_count, [31:24] zero
  output logic [31:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  u8d_pkg::seq_t    seq_q;
  logic             in_vld_q;
  u8d_pkg::result_t res_d;
  u8d_pkg::result_t res_q;
  logic             out_vld_q;
  logic             out_load;
  logic             in_load;

  assign out_load        = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !in_vld_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      seq_q <= s_axis_tdata_i;
    end
  end

  u8d_decode u_decode (
    .seq_i (seq_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {8'd0, res_q.byte_count, res_q.code_point};
  assign m_axis_tuser_o  = res_q.status;

`ifndef ASSERT_OFF
  // An error result never carries a code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status != u8d_pkg::StOk |-> res_q.code_point == '0)
    else $error("error result carries a non-zero code point");

  // A bad lead byte consumes nothing; any other result consumes one to four bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((res_q.status == u8d_pkg::StBadLead) == (res_q.byte_count == '0))
                  && res_q.byte_count <= 3'd4)
    else $error("byte count inconsistent with status");

  // A good result stays within the Unicode range, and a single byte stays below 0x100.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status == u8d_pkg::StOk
      |-> res_q.code_point <= u8d_pkg::MaxScalar
          && (res_q.byte_count != 3'd1 || res_q.code_point[20:8] == '0))
    else $error("good result out of range");

  // An empty result register always leaves room for a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready_o)
    else $error("input stalled while result register empty");
`endif

endmodule
